// File: rtl/rwg_pkg.sv
package rwg_pkg;

  // Longest waveform the generator serves; later indices give zero.
  localparam logic [20:0] MAX_SAMPLES = 21'd65536;

  // Fixed-point constants, Q28 (HALF_Q24 is in Q24)
  localparam logic [47:0] PI_Q28    = 48'd843314857;
  localparam logic [47:0] TAIL_Q28  = 48'd1207959552;
  localparam logic [28:0] LOG2E_Q28 = 29'd387270501;
  localparam logic [33:0] ONE_Q28   = 34'd268435456;
  localparam logic [27:0] HALF_Q28  = 28'd134217728;
  localparam logic [23:0] HALF_Q24  = 24'd8388608;

  // 2^(-k/16) in Q16, k = 0..16
  localparam logic [16:0] EXP2_TAB [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  // Beat leaving the squaring front end
  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [32:0] xx;
  } rwg_sq_t;

  // Beat leaving the exponential stage: exp value and polynomial factor
  typedef struct packed {
    logic        valid;
    logic        zero;
    logic        neg;
    logic [4:0]  n;
    logic [33:0] fmag;
    logic [16:0] v;
  } rwg_ex_t;

endpackage

// File: rtl/ricker_wavelet_generator_core.sv
// Ricker wavelet sample generator. Each beat taken on start returns one signed Q1.15
// sample of exp(-x^2)*(1-2x^2), with x = x_step*sample_index - pi, on sample_value_o,
// marked by strobe_o for one cycle. A new beat is taken in every cycle: busy stays
// low, and the pipeline holds the phase, square, log2(e), interpolation and scaling
// multipliers, each in a stage of its own. Results cannot be held off, so the
// receiver must take each one when strobe_o is high. Write x_step (unsigned Q4.28)
// only while no beat is in flight.
module ricker_wavelet_generator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic [15:0]        sample_index_i,
  output logic               strobe_o,
  output logic signed [15:0] sample_value_o
);
  import rwg_pkg::*;

  logic [31:0] x_step_q;
  logic        in_valid;
  rwg_sq_t     sq;
  rwg_ex_t     ex;
  logic [15:0] value;

  // Hold the step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_step_q <= 32'd0;
    end else if (cfg_we_i) begin
      x_step_q <= cfg_wdata_i;
    end
  end

  // The pipeline never stalls
  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  rwg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .sample_index_i (sample_index_i),
    .x_step_i       (x_step_q),
    .sq_o           (sq)
  );

  rwg_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sq_i   (sq),
    .ex_o   (ex)
  );

  rwg_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ex_i           (ex),
    .strobe_o       (strobe_o),
    .sample_value_o (value)
  );

  assign sample_value_o = signed'(value);

endmodule

// File: rtl/rwg_front.sv
module rwg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [15:0]     sample_index_i,
  input  logic [31:0]     x_step_i,
  output rwg_pkg::rwg_sq_t sq_o
);
  import rwg_pkg::*;

  logic        v1_q, v2_q, v3_q;
  logic        oor1_d, oor1_q;
  logic [47:0] p1_d, p1_q;
  logic [47:0] ax_d;
  logic        zero2_d, zero2_q, zero3_q;
  logic [30:0] ax2_q;
  logic [62:0] sq_sum;
  logic [32:0] xx3_d, xx3_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1: phase product, range check
  assign p1_d   = 48'(x_step_i) * 48'(sample_index_i);
  assign oor1_d = {5'd0, sample_index_i} >= MAX_SAMPLES;

  // Stage 2: distance from the wavelet center, tail check
  assign ax_d    = (p1_q >= PI_Q28) ? (p1_q - PI_Q28) : (PI_Q28 - p1_q);
  assign zero2_d = oor1_q | (ax_d > TAIL_Q28);

  // Stage 3: square with rounding; only values inside the tail matter
  assign sq_sum = 63'(ax2_q) * 63'(ax2_q) + 63'(HALF_Q28);
  assign xx3_d  = sq_sum[60:28];

  always_ff @(posedge clk_i) begin
    p1_q    <= p1_d;
    oor1_q  <= oor1_d;
    ax2_q   <= ax_d[30:0];
    zero2_q <= zero2_d;
    xx3_q   <= xx3_d;
    zero3_q <= zero2_q;
  end

  assign sq_o.valid = v3_q;
  assign sq_o.zero  = zero3_q;
  assign sq_o.xx    = xx3_q;

endmodule

// File: rtl/rwg_exp.sv
module rwg_exp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rwg_pkg::rwg_sq_t sq_i,
  output rwg_pkg::rwg_ex_t ex_o
);
  import rwg_pkg::*;

  logic        v4_q, v5_q, v6_q;
  logic        zero4_q, zero5_q, zero6_q;
  logic        neg4_d, neg4_q, neg5_q, neg6_q;
  logic [33:0] xx2;
  logic [33:0] fmag4_d, fmag4_q, fmag5_q, fmag6_q;
  logic [61:0] y_sum;
  logic [32:0] y4_q;
  logic [4:0]  tidx;
  logic [4:0]  n5_q, n6_q;
  logic [16:0] tab0_d, tab1_d, tab0_q;
  logic [11:0] dlt_q;
  logic [23:0] rem_q;
  logic [35:0] ip;
  logic [16:0] val6_d, val6_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= sq_i.valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  // Stage 4: exponent in base 2, and the factor 1 - 2x^2 as sign and magnitude
  assign y_sum   = 62'(sq_i.xx) * 62'(LOG2E_Q28) + 62'(HALF_Q28);
  assign xx2     = {sq_i.xx, 1'b0};
  assign neg4_d  = xx2 > ONE_Q28;
  assign fmag4_d = neg4_d ? (xx2 - ONE_Q28) : (ONE_Q28 - xx2);

  // Stage 5: table lookup on the fractional exponent
  assign tidx   = {1'b0, y4_q[27:24]};
  assign tab0_d = EXP2_TAB[tidx];
  assign tab1_d = EXP2_TAB[tidx + 5'd1];

  // Stage 6: linear interpolation between neighbors
  assign ip     = 36'(dlt_q) * 36'(rem_q) + 36'(HALF_Q24);
  assign val6_d = tab0_q - 17'(ip[35:24]);

  always_ff @(posedge clk_i) begin
    y4_q    <= y_sum[60:28];
    neg4_q  <= neg4_d;
    fmag4_q <= fmag4_d;
    zero4_q <= sq_i.zero;

    tab0_q  <= tab0_d;
    dlt_q   <= 12'(tab0_d - tab1_d);
    rem_q   <= y4_q[23:0];
    n5_q    <= y4_q[32:28];
    neg5_q  <= neg4_q;
    fmag5_q <= fmag4_q;
    zero5_q <= zero4_q;

    val6_q  <= val6_d;
    n6_q    <= n5_q;
    neg6_q  <= neg5_q;
    fmag6_q <= fmag5_q;
    zero6_q <= zero5_q;
  end

  assign ex_o.valid = v6_q;
  assign ex_o.zero  = zero6_q;
  assign ex_o.neg   = neg6_q;
  assign ex_o.n     = n6_q;
  assign ex_o.fmag  = fmag6_q;
  assign ex_o.v     = val6_q;

endmodule

// File: rtl/rwg_scale.sv
module rwg_scale (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rwg_pkg::rwg_ex_t ex_i,
  output logic             strobe_o,
  output logic [15:0]      sample_value_o
);
  import rwg_pkg::*;

  logic        v7_q, v8_q, v9_q;
  logic        zero7_q, zero8_q;
  logic        neg7_q, neg8_q;
  logic [4:0]  n7_q;
  logic [50:0] mag7_q;
  logic [5:0]  sh;
  logic [50:0] shifted;
  logic [22:0] t8_q;
  logic [23:0] t_inc;
  logic [22:0] r;
  logic [15:0] val9_d, val9_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v7_q <= ex_i.valid;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // Stage 8: scale by 2^-(28+n); the last rounding bit stays in bit 0
  assign sh      = 6'd28 + {1'b0, n7_q};
  assign shifted = mag7_q >> sh;

  // Stage 9: round the magnitude half up, saturate, drop tail and out-of-range samples
  assign t_inc = {1'b0, t8_q} + 24'd1;
  assign r     = t_inc[23:1];

  always_comb begin
    if (zero8_q) begin
      val9_d = 16'd0;
    end else if (neg8_q) begin
      val9_d = (r > 23'd32768) ? 16'h8000 : 16'(23'd0 - r);
    end else begin
      val9_d = (r > 23'd32767) ? 16'h7fff : r[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mag7_q  <= 51'(ex_i.v) * 51'(ex_i.fmag);
    n7_q    <= ex_i.n;
    neg7_q  <= ex_i.neg;
    zero7_q <= ex_i.zero;

    t8_q    <= shifted[22:0];
    neg8_q  <= neg7_q;
    zero8_q <= zero7_q;

    val9_q  <= val9_d;
  end

  assign strobe_o       = v9_q;
  assign sample_value_o = val9_q;

endmodule

// File: rtl/rwg_checker.sv
module rwg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               cfg_we_i,
  input logic [15:0]        sample_index_i,
  input logic               strobe_o,
  input logic signed [15:0] sample_value_o
);

  // Every accepted beat yields its sample strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##9 strobe_o)
    else $error("accepted beat produced no sample after nine cycles");

  // No sample without an accepted beat before it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy, 9))
    else $error("sample strobe without a matching beat");

  // Two equal indices in a row under the same step give equal samples
  a_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cfg_we_i) ##1
    (start && !busy && (sample_index_i == $past(sample_index_i)))
    |-> ##9 (strobe_o && $stable(sample_value_o)))
    else $error("equal indices gave different samples");

endmodule

bind ricker_wavelet_generator_core rwg_checker u_rwg_checker (.*);
